// ===== design/gtbd_pkg.sv =====
// ----------------------------------------------------------------------------
// gtbd_pkg
// Request codes, register indexes and fixed field widths of the graph store.
// ----------------------------------------------------------------------------
`default_nettype none

package gtbd_pkg;

  typedef enum logic [1:0] {
    REQ_ADD    = 2'd0,
    REQ_REMOVE = 2'd1,
    REQ_QUERY  = 2'd2,
    REQ_DIST   = 2'd3
  } req_t;

  localparam logic CFG_DIRECTED = 1'b0;
  localparam logic CFG_VCOUNT   = 1'b1;

  localparam int VERT_W = 6;
  localparam int VCNT_W = 7;
  localparam int CNT_W  = 16;
  localparam int DEG_W  = 10;
  localparam int HOP_W  = 6;

endpackage

`default_nettype wire

// ===== design/graph_table_bfs_distance.sv =====
// ----------------------------------------------------------------------------
// graph_table_bfs_distance
// Graph of edge multiplicity counts with pair queries and hop distance search.
// ----------------------------------------------------------------------------
// Usage: raise start with a request on the in_ ports while busy is low; the
// request transfers at that edge. Exactly one result follows, shown for one
// cycle with out_valid high; the receiver cannot stall it.
// The edge store is held as one row per vertex in a single-port-read memory;
// every row access gives registered read data.
// Out-of-range requests answer at once, busy low. Add/remove update row u,
// then row v if undirected and u != v. A pair query sums one counter lane or
// one row per cycle through a shared saturating adder; a distance search reads
// one row per visited vertex, level by level. busy is high while work runs.
// Configuration writes transfer on cfg_valid/cfg_ready while no request is
// in progress. Writing vertex_count clears the store, all MAX_VERTICES rows,
// one row per cycle while busy. Reset runs the same clearing sweep.
// ----------------------------------------------------------------------------
`default_nettype none

module graph_table_bfs_distance #(
  parameter int MAX_VERTICES = 64,
  parameter int MULT_BITS    = 4
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         start,
  output logic                              busy,
  input  wire logic [1:0]                   in_req_type,
  input  wire logic [gtbd_pkg::VERT_W-1:0]  in_vert_u,
  input  wire logic [gtbd_pkg::VERT_W-1:0]  in_vert_v,
  input  wire logic                         in_count_incoming,
  output logic                              out_valid,
  output logic                              out_accepted,
  output logic                              out_edge_present,
  output logic                              out_shares_neighbour,
  output logic [gtbd_pkg::DEG_W-1:0]        out_vertex_degree,
  output logic [gtbd_pkg::HOP_W-1:0]        out_hop_distance,
  output logic                              out_reached,
  output logic [gtbd_pkg::CNT_W-1:0]        out_edge_total,
  input  wire logic                         cfg_valid,
  output logic                              cfg_ready,
  input  wire logic                         cfg_index,
  input  wire logic [gtbd_pkg::VCNT_W-1:0]  cfg_data
);

  localparam int VW    = $clog2(MAX_VERTICES);
  localparam int NW    = $clog2(MAX_VERTICES + 1);
  localparam int CW    = (NW > gtbd_pkg::VERT_W) ? NW : gtbd_pkg::VERT_W;
  localparam int KW    = (NW > gtbd_pkg::VCNT_W) ? NW : gtbd_pkg::VCNT_W;
  localparam int ROW_W = MAX_VERTICES * MULT_BITS;
  localparam int N_RST = (MAX_VERTICES < 64) ? MAX_VERTICES : 64;

  localparam logic [MULT_BITS-1:0]       MULT_MAX = '1;
  localparam logic [VW-1:0]              LAST_ROW = VW'(MAX_VERTICES - 1);
  localparam logic [KW-1:0]              K_MAX    = KW'(MAX_VERTICES);
  localparam logic [gtbd_pkg::CNT_W-1:0] CNT_TOP  = '1;
  localparam logic [gtbd_pkg::HOP_W-1:0] HOP_TOP  = '1;
  localparam logic [gtbd_pkg::DEG_W:0]   DEG_TOP  = {1'b0, {gtbd_pkg::DEG_W{1'b1}}};

  typedef enum logic [6:0] {
    S_IDLE      = 7'b0000001,
    S_CLEAR     = 7'b0000010,
    S_GOT_U     = 7'b0000100,
    S_GOT_V     = 7'b0001000,
    S_DEG       = 7'b0010000,
    S_BFS_ISSUE = 7'b0100000,
    S_BFS_PROC  = 7'b1000000
  } state_t;

  function automatic logic [MULT_BITS-1:0] lane(input logic [ROW_W-1:0] r,
                                                input logic [VW-1:0] idx);
    lane = r[idx*MULT_BITS +: MULT_BITS];
  endfunction

  function automatic logic [ROW_W-1:0] set_lane(input logic [ROW_W-1:0] r,
                                                input logic [VW-1:0] idx,
                                                input logic [MULT_BITS-1:0] val);
    logic [ROW_W-1:0] t;
    t = r;
    t[idx*MULT_BITS +: MULT_BITS] = val;
    set_lane = t;
  endfunction

  function automatic logic [MAX_VERTICES-1:0] nz(input logic [ROW_W-1:0] r);
    logic [MAX_VERTICES-1:0] m;
    for (int i = 0; i < MAX_VERTICES; i++) begin
      m[i] = |r[i*MULT_BITS +: MULT_BITS];
    end
    nz = m;
  endfunction

  function automatic logic [VW-1:0] enc(input logic [MAX_VERTICES-1:0] oh);
    logic [VW-1:0] x;
    x = '0;
    for (int i = 0; i < MAX_VERTICES; i++) begin
      if (oh[i]) begin
        x = x | VW'(i);
      end
    end
    enc = x;
  endfunction

  state_t                      state_r, state_nxt;
  gtbd_pkg::req_t              req_r, req_nxt;
  logic [VW-1:0]               u_r, u_nxt, v_r, v_nxt, clr_r, clr_nxt;
  logic                        inc_r, inc_nxt, dir_r, dir_nxt;
  logic [NW-1:0]               nv_r, nv_nxt, w_r, w_nxt;
  logic [ROW_W-1:0]            row_u_r, row_u_nxt;
  logic [gtbd_pkg::CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [gtbd_pkg::DEG_W-1:0]  deg_r, deg_nxt;
  logic                        share_r, share_nxt, pres_r, pres_nxt;
  logic [MAX_VERTICES-1:0]     visited_r, visited_nxt, front_r, front_nxt;
  logic [MAX_VERTICES-1:0]     next_r, next_nxt;
  logic [gtbd_pkg::HOP_W-1:0]  level_r, level_nxt;

  logic                        out_valid_r, out_valid_nxt;
  logic                        o_acc_r, o_acc_nxt, o_pres_r, o_pres_nxt;
  logic                        o_share_r, o_share_nxt, o_reach_r, o_reach_nxt;
  logic [gtbd_pkg::DEG_W-1:0]  o_deg_r, o_deg_nxt;
  logic [gtbd_pkg::HOP_W-1:0]  o_hop_r, o_hop_nxt;
  logic [gtbd_pkg::CNT_W-1:0]  o_tot_r;

  logic                        mem_we;
  logic [VW-1:0]               mem_wa, mem_ra;
  logic [ROW_W-1:0]            mem_wd, mem_rd;

  logic [CW-1:0]               uc, vc;
  logic [KW-1:0]               kc;
  logic [MULT_BITS-1:0]        cuv, cvu, cell_w;
  logic [MULT_BITS:0]          term;
  logic [gtbd_pkg::DEG_W:0]    sum;
  logic [MAX_VERTICES-1:0]     low, nb;
  logic [gtbd_pkg::HOP_W-1:0]  lvl1;

  gtbd_row_mem #(
    .DEPTH (MAX_VERTICES),
    .WIDTH (ROW_W)
  ) u_mem (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (mem_wa),
    .wr_data (mem_wd),
    .rd_addr (mem_ra),
    .rd_data (mem_rd)
  );

  always_comb begin
    state_nxt     = state_r;
    req_nxt       = req_r;
    u_nxt         = u_r;
    v_nxt         = v_r;
    clr_nxt       = clr_r;
    inc_nxt       = inc_r;
    dir_nxt       = dir_r;
    nv_nxt        = nv_r;
    w_nxt         = w_r;
    row_u_nxt     = row_u_r;
    cnt_nxt       = cnt_r;
    deg_nxt       = deg_r;
    share_nxt     = share_r;
    pres_nxt      = pres_r;
    visited_nxt   = visited_r;
    front_nxt     = front_r;
    next_nxt      = next_r;
    level_nxt     = level_r;
    out_valid_nxt = 1'b0;
    o_acc_nxt     = 1'b0;
    o_pres_nxt    = 1'b0;
    o_share_nxt   = 1'b0;
    o_reach_nxt   = 1'b0;
    o_deg_nxt     = '0;
    o_hop_nxt     = '0;
    mem_we        = 1'b0;
    mem_wa        = u_r;
    mem_wd        = '0;
    mem_ra        = u_r;

    uc     = CW'(in_vert_u);
    vc     = CW'(in_vert_v);
    cuv    = lane(mem_rd, v_r);
    cvu    = lane(mem_rd, u_r);
    cell_w = (dir_r && inc_r) ? cvu : lane(row_u_r, w_r[VW-1:0]);
    term   = (!dir_r && w_r[VW-1:0] == u_r) ? {cell_w, 1'b0} : {1'b0, cell_w};
    sum    = {1'b0, deg_r} + (gtbd_pkg::DEG_W + 1)'(term);
    low    = front_r & (~front_r + 1'b1);
    nb     = nz(mem_rd) & ~visited_r;
    lvl1   = (level_r == HOP_TOP) ? HOP_TOP : level_r + 1'b1;

    unique case (state_r)
      S_CLEAR: begin
        mem_we  = 1'b1;
        mem_wa  = clr_r;
        clr_nxt = clr_r + 1'b1;
        if (clr_r == LAST_ROW) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          req_nxt = gtbd_pkg::req_t'(in_req_type);
          u_nxt   = uc[VW-1:0];
          v_nxt   = vc[VW-1:0];
          inc_nxt = in_count_incoming;
          mem_ra  = uc[VW-1:0];
          if (uc < CW'(nv_r) && vc < CW'(nv_r)) begin
            state_nxt = S_GOT_U;
          end else begin
            out_valid_nxt = 1'b1;
          end
        end
      end
      S_GOT_U: begin
        row_u_nxt = mem_rd;
        mem_ra    = v_r;
        unique case (req_r)
          gtbd_pkg::REQ_ADD: begin
            if (cuv != MULT_MAX) begin
              mem_we  = 1'b1;
              mem_wd  = set_lane(mem_rd, v_r, cuv + 1'b1);
              cnt_nxt = (cnt_r == CNT_TOP) ? cnt_r : cnt_r + 1'b1;
              if (!dir_r && u_r != v_r) begin
                state_nxt = S_GOT_V;
              end else begin
                state_nxt = S_IDLE; out_valid_nxt = 1'b1; o_acc_nxt = 1'b1;
              end
            end else begin
              state_nxt = S_IDLE; out_valid_nxt = 1'b1;
            end
          end
          gtbd_pkg::REQ_REMOVE: begin
            if (cuv != '0) begin
              mem_we  = 1'b1;
              mem_wd  = set_lane(mem_rd, v_r, cuv - 1'b1);
              cnt_nxt = (cnt_r == '0) ? cnt_r : cnt_r - 1'b1;
              if (!dir_r && u_r != v_r) begin
                state_nxt = S_GOT_V;
              end else begin
                state_nxt = S_IDLE; out_valid_nxt = 1'b1; o_acc_nxt = 1'b1;
              end
            end else begin
              state_nxt = S_IDLE; out_valid_nxt = 1'b1;
            end
          end
          gtbd_pkg::REQ_QUERY: begin
            pres_nxt  = (cuv != '0);
            state_nxt = S_GOT_V;
          end
          gtbd_pkg::REQ_DIST: begin
            visited_nxt = '0;
            visited_nxt[u_r] = 1'b1;
            front_nxt   = visited_nxt;
            next_nxt    = '0;
            level_nxt   = '0;
            if (u_r == v_r) begin
              state_nxt = S_IDLE; out_valid_nxt = 1'b1;
              o_acc_nxt = 1'b1; o_reach_nxt = 1'b1;
            end else begin
              state_nxt = S_BFS_ISSUE;
            end
          end
        endcase
      end
      S_GOT_V: begin
        mem_wa = v_r;
        mem_ra = '0;
        unique case (req_r)
          gtbd_pkg::REQ_ADD: begin
            mem_we = 1'b1;
            mem_wd = set_lane(mem_rd, u_r, cvu + 1'b1);
            state_nxt = S_IDLE; out_valid_nxt = 1'b1; o_acc_nxt = 1'b1;
          end
          gtbd_pkg::REQ_REMOVE: begin
            mem_we = (cvu != '0);
            mem_wd = set_lane(mem_rd, u_r, cvu - 1'b1);
            state_nxt = S_IDLE; out_valid_nxt = 1'b1; o_acc_nxt = 1'b1;
          end
          gtbd_pkg::REQ_QUERY: begin
            share_nxt = |(nz(row_u_r) & nz(mem_rd));
            deg_nxt   = '0;
            w_nxt     = '0;
            state_nxt = S_DEG;
          end
          gtbd_pkg::REQ_DIST: begin
            state_nxt = S_IDLE;
          end
        endcase
      end
      S_DEG: begin
        deg_nxt = (sum > DEG_TOP) ? DEG_TOP[gtbd_pkg::DEG_W-1:0] : sum[gtbd_pkg::DEG_W-1:0];
        w_nxt   = w_r + 1'b1;
        mem_ra  = w_nxt[VW-1:0];
        if (w_nxt == nv_r) begin
          state_nxt   = S_IDLE;
          out_valid_nxt = 1'b1;
          o_acc_nxt   = 1'b1;
          o_pres_nxt  = pres_r;
          o_share_nxt = share_r;
          o_deg_nxt   = deg_nxt;
        end
      end
      S_BFS_ISSUE: begin
        if (|front_r) begin
          front_nxt = front_r & ~low;
          mem_ra    = enc(low);
          state_nxt = S_BFS_PROC;
        end else if (|next_r) begin
          front_nxt = next_r;
          next_nxt  = '0;
          level_nxt = lvl1;
        end else begin
          state_nxt = S_IDLE; out_valid_nxt = 1'b1; o_acc_nxt = 1'b1;
        end
      end
      S_BFS_PROC: begin
        visited_nxt = visited_r | nb;
        next_nxt    = next_r | nb;
        if (nb[v_r]) begin
          state_nxt = S_IDLE; out_valid_nxt = 1'b1;
          o_acc_nxt = 1'b1; o_reach_nxt = 1'b1; o_hop_nxt = lvl1;
        end else begin
          state_nxt = S_BFS_ISSUE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    kc = KW'(cfg_data);
    if (cfg_valid && cfg_ready) begin
      if (cfg_index == gtbd_pkg::CFG_DIRECTED) begin
        dir_nxt = cfg_data[0];
      end else begin
        priority if (kc == '0) begin
          nv_nxt = NW'(1);
        end else if (kc > K_MAX) begin
          nv_nxt = NW'(MAX_VERTICES);
        end else begin
          nv_nxt = kc[NW-1:0];
        end
        cnt_nxt   = '0;
        clr_nxt   = '0;
        state_nxt = S_CLEAR;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      dir_r       <= 1'b0;
      nv_r        <= NW'(N_RST);
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      dir_r       <= dir_nxt;
      nv_r        <= nv_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r     <= req_nxt;
    u_r       <= u_nxt;
    v_r       <= v_nxt;
    inc_r     <= inc_nxt;
    w_r       <= w_nxt;
    row_u_r   <= row_u_nxt;
    deg_r     <= deg_nxt;
    share_r   <= share_nxt;
    pres_r    <= pres_nxt;
    visited_r <= visited_nxt;
    front_r   <= front_nxt;
    next_r    <= next_nxt;
    level_r   <= level_nxt;
    o_acc_r   <= o_acc_nxt;
    o_pres_r  <= o_pres_nxt;
    o_share_r <= o_share_nxt;
    o_reach_r <= o_reach_nxt;
    o_deg_r   <= o_deg_nxt;
    o_hop_r   <= o_hop_nxt;
    o_tot_r   <= cnt_nxt;
  end

  assign busy                 = (state_r != S_IDLE);
  assign cfg_ready            = (state_r == S_IDLE) || (state_r == S_CLEAR);
  assign out_valid            = out_valid_r;
  assign out_accepted         = o_acc_r;
  assign out_edge_present     = o_pres_r;
  assign out_shares_neighbour = o_share_r;
  assign out_vertex_degree    = o_deg_r;
  assign out_hop_distance     = o_hop_r;
  assign out_reached          = o_reach_r;
  assign out_edge_total       = o_tot_r;

  a_clear_on_vcount: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_valid && cfg_ready && cfg_index == gtbd_pkg::CFG_VCOUNT)
      |=> (cnt_r == '0 && state_r == S_CLEAR))
    else $error("vertex count write did not start a clearing sweep");

  a_flags_need_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (o_reach_r || o_pres_r || o_share_r)) |-> o_acc_r)
    else $error("result flag set on a refused request");

  a_start_progress: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && !(cfg_valid && cfg_ready)) |=> (busy || out_valid_r))
    else $error("transfer neither started work nor gave a result");

endmodule

`default_nettype wire

// ===== design/gtbd_row_mem.sv =====
// ----------------------------------------------------------------------------
// gtbd_row_mem
// Adjacency row store: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`default_nettype none

module gtbd_row_mem #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the graph store: a model of the edge table and of
// the breadth-first search predicts every result, which the monitor checks
// field by field. Requests run in phases with different sender idling and
// register settings.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NV = 64;
  localparam int LIMIT = 2000000;

  typedef struct packed {
    gtbd_pkg::req_t                  kind;
    logic [gtbd_pkg::VERT_W-1:0]     u;
    logic [gtbd_pkg::VERT_W-1:0]     v;
    logic                            incoming;
  } request_t;

  typedef struct packed {
    logic                            accepted;
    logic                            present;
    logic                            shares;
    logic [gtbd_pkg::DEG_W-1:0]      degree;
    logic [gtbd_pkg::HOP_W-1:0]      hops;
    logic                            reached;
    logic [gtbd_pkg::CNT_W-1:0]      total;
  } answer_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [1:0] in_req_type = '0;
  logic [gtbd_pkg::VERT_W-1:0] in_vert_u = '0;
  logic [gtbd_pkg::VERT_W-1:0] in_vert_v = '0;
  logic in_count_incoming = 1'b0;
  logic out_valid, out_accepted, out_edge_present, out_shares_neighbour, out_reached;
  logic [gtbd_pkg::DEG_W-1:0] out_vertex_degree;
  logic [gtbd_pkg::HOP_W-1:0] out_hop_distance;
  logic [gtbd_pkg::CNT_W-1:0] out_edge_total;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic cfg_index = 1'b0;
  logic [gtbd_pkg::VCNT_W-1:0] cfg_data = '0;

  graph_table_bfs_distance i_dut (
    .clk, .rst_n, .start, .busy, .in_req_type, .in_vert_u, .in_vert_v,
    .in_count_incoming, .out_valid, .out_accepted, .out_edge_present,
    .out_shares_neighbour, .out_vertex_degree, .out_hop_distance, .out_reached,
    .out_edge_total, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // model state
  logic [3:0] mult [NV][NV];
  logic [gtbd_pkg::CNT_W-1:0] stored_edges;
  logic directed;
  logic [gtbd_pkg::VCNT_W-1:0] vcount_reg;

  request_t pending_reqs[$];
  answer_t expected_answers[$];
  int errors = 0;
  int cycles = 0;
  int idle_pct = 0;
  bit hold_off = 1'b0;

  task automatic report(input string what, input int got, input int want);
    $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  function automatic void clear_graph();
    for (int a = 0; a < NV; a++)
      for (int b = 0; b < NV; b++) mult[a][b] = '0;
    stored_edges = '0;
  endfunction

  function automatic int live_vertices();
    if (vcount_reg == 0) return 1;
    if (vcount_reg > NV) return NV;
    return vcount_reg;
  endfunction

  function automatic answer_t predict_answer(request_t r);
    answer_t a;
    int n, sum, head, tail, cur;
    int seen [NV];
    int hop [NV];
    int fifo [NV];
    a = '0;
    n = live_vertices();
    if (r.u < n && r.v < n) begin
      case (r.kind)
        gtbd_pkg::REQ_ADD: begin
          if (mult[r.u][r.v] != 4'hf) begin
            mult[r.u][r.v]++;
            if (!directed && r.u != r.v) mult[r.v][r.u]++;
            if (stored_edges != 16'hffff) stored_edges++;
            a.accepted = 1'b1;
          end
        end
        gtbd_pkg::REQ_REMOVE: begin
          if (mult[r.u][r.v] != 0) begin
            mult[r.u][r.v]--;
            if (!directed && r.u != r.v && mult[r.v][r.u] != 0) mult[r.v][r.u]--;
            if (stored_edges != 0) stored_edges--;
            a.accepted = 1'b1;
          end
        end
        gtbd_pkg::REQ_QUERY: begin
          a.accepted = 1'b1;
          a.present = mult[r.u][r.v] != 0;
          sum = 0;
          for (int w = 0; w < n; w++) begin
            if (mult[r.u][w] != 0 && mult[r.v][w] != 0) a.shares = 1'b1;
            if (directed) sum += r.incoming ? mult[w][r.u] : mult[r.u][w];
            else sum += (w == r.u) ? 2 * mult[r.u][r.u] : mult[r.u][w];
          end
          a.degree = sum > 1023 ? 10'd1023 : (gtbd_pkg::DEG_W)'(sum);
        end
        default: begin
          a.accepted = 1'b1;
          for (int i = 0; i < n; i++) begin
            seen[i] = 0;
            hop[i] = 0;
          end
          head = 0;
          tail = 1;
          fifo[0] = r.u;
          seen[r.u] = 1;
          while (head < tail) begin
            cur = fifo[head++];
            for (int w = 0; w < n; w++)
              if (!seen[w] && mult[cur][w] != 0 && tail < n) begin
                seen[w] = 1;
                hop[w] = hop[cur] + 1;
                fifo[tail++] = w;
              end
          end
          if (seen[r.v]) begin
            a.reached = 1'b1;
            a.hops = hop[r.v] > 63 ? 6'd63 : (gtbd_pkg::HOP_W)'(hop[r.v]);
          end
        end
      endcase
    end
    a.total = stored_edges;
    return a;
  endfunction

  // driver
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
    if (start && !busy) begin
      expected_answers.push_back(predict_answer(request_t'({gtbd_pkg::req_t'(in_req_type),
        in_vert_u, in_vert_v, in_count_incoming})));
    end
    if (!start || !busy) begin
      if (rst_n && pending_reqs.size() > 0 && !hold_off &&
          $urandom_range(99) >= idle_pct) begin
        request_t r;
        r = pending_reqs.pop_front();
        start <= 1'b1;
        in_req_type <= r.kind;
        in_vert_u <= r.u;
        in_vert_v <= r.v;
        in_count_incoming <= r.incoming;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (expected_answers.size() == 0) begin
        report("unexpected result", 1, 0);
      end else begin
        answer_t e;
        e = expected_answers.pop_front();
        if (out_accepted !== e.accepted) report("accepted", out_accepted, e.accepted);
        if (out_edge_present !== e.present) report("edge_present", out_edge_present, e.present);
        if (out_shares_neighbour !== e.shares)
          report("shares_neighbour", out_shares_neighbour, e.shares);
        if (out_vertex_degree !== e.degree) report("degree", out_vertex_degree, e.degree);
        if (out_hop_distance !== e.hops) report("hop_distance", out_hop_distance, e.hops);
        if (out_reached !== e.reached) report("reached", out_reached, e.reached);
        if (out_edge_total !== e.total) report("edge_total", out_edge_total, e.total);
      end
    end
  end

  task automatic drain();
    while (pending_reqs.size() > 0 || start || busy || expected_answers.size() > 0)
      @(posedge clk);
    repeat (3 * NV + 10) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input int value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= (gtbd_pkg::VCNT_W)'(value);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == gtbd_pkg::CFG_DIRECTED) directed = value[0];
    else begin
      vcount_reg = (gtbd_pkg::VCNT_W)'(value);
      clear_graph();
    end
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic push_req(input gtbd_pkg::req_t k, input int u, input int v, input bit inc);
    pending_reqs.push_back('{k, (gtbd_pkg::VERT_W)'(u), (gtbd_pkg::VERT_W)'(v), inc});
  endtask

  // mostly in-range vertices, a few over the top to hit the range check
  function automatic int pick_vertex(int n);
    if ($urandom_range(15) == 0) return $urandom_range(63);
    return $urandom_range(n - 1);
  endfunction

  task automatic random_phase(input int count, input int n);
    int k;
    for (int i = 0; i < count; i++) begin
      k = $urandom_range(9);
      push_req(k < 4 ? gtbd_pkg::REQ_ADD : k < 6 ? gtbd_pkg::REQ_REMOVE :
               k < 8 ? gtbd_pkg::REQ_QUERY : gtbd_pkg::REQ_DIST,
               pick_vertex(n), pick_vertex(n), $urandom_range(1));
    end
  endtask

  initial begin
    directed = 1'b0;
    vcount_reg = 7'd64;
    clear_graph();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);

    // undirected: extremes, self-loops, saturation, missing remove
    push_req(gtbd_pkg::REQ_ADD, 0, 63, 0);
    push_req(gtbd_pkg::REQ_ADD, 63, 63, 0);
    push_req(gtbd_pkg::REQ_QUERY, 63, 63, 0);
    push_req(gtbd_pkg::REQ_QUERY, 63, 0, 1);
    push_req(gtbd_pkg::REQ_REMOVE, 5, 6, 0);
    for (int i = 0; i < 16; i++) push_req(gtbd_pkg::REQ_ADD, 7, 8, 0);
    push_req(gtbd_pkg::REQ_QUERY, 7, 0, 0);
    push_req(gtbd_pkg::REQ_DIST, 0, 63, 0);
    push_req(gtbd_pkg::REQ_DIST, 63, 0, 0);
    push_req(gtbd_pkg::REQ_DIST, 4, 4, 0);
    push_req(gtbd_pkg::REQ_DIST, 1, 2, 0);
    drain();

    write_reg(gtbd_pkg::CFG_DIRECTED, 1);
    write_reg(gtbd_pkg::CFG_VCOUNT, 0);
    push_req(gtbd_pkg::REQ_ADD, 0, 0, 0);
    push_req(gtbd_pkg::REQ_ADD, 0, 1, 0);
    push_req(gtbd_pkg::REQ_QUERY, 0, 0, 1);
    push_req(gtbd_pkg::REQ_DIST, 0, 0, 0);
    drain();

    write_reg(gtbd_pkg::CFG_VCOUNT, 127);
    for (int i = 0; i < 63; i++) push_req(gtbd_pkg::REQ_ADD, i, i + 1, 0);
    push_req(gtbd_pkg::REQ_DIST, 0, 63, 0);
    push_req(gtbd_pkg::REQ_QUERY, 5, 0, 1);
    random_phase(250, 8);
    drain();

    idle_pct = 79;
    write_reg(gtbd_pkg::CFG_DIRECTED, 0);
    write_reg(gtbd_pkg::CFG_VCOUNT, 12);
    random_phase(200, 12);
    drain();

    // hold-off mid-stream until all results are in, then resume
    idle_pct = 0;
    random_phase(50, 12);
    repeat (60) @(posedge clk);
    hold_off = 1'b1;
    while (start || busy || expected_answers.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
    hold_off = 1'b0;
    drain();

    idle_pct = 17;
    write_reg(gtbd_pkg::CFG_VCOUNT, 64);
    random_phase(300, 64);
    drain();

    idle_pct = 0;
    write_reg(gtbd_pkg::CFG_DIRECTED, 1);
    write_reg(gtbd_pkg::CFG_VCOUNT, 2);
    random_phase(150, 2);
    drain();

    idle_pct = 79;
    write_reg(gtbd_pkg::CFG_VCOUNT, 20);
    random_phase(250, 20);
    drain();

    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== files.f =====
design/gtbd_pkg.sv
design/gtbd_row_mem.sv
design/graph_table_bfs_distance.sv
tb/testbench.sv
